// ===== rtl/btc_pkg.sv =====
// Shared types and constants for the bitmap font text console.
// No dependencies; every other file in rtl/ imports this package.
package btc_pkg;

	// Font geometry and cursor range
	localparam int GLYPH_ROWS  = 16;
	localparam int GLYPH_COUNT = 256;
	localparam int COORD_BITS  = 12;
	localparam int ROW_BITS    = $clog2(GLYPH_ROWS);
	localparam int CODE_BITS   = $clog2(GLYPH_COUNT);
	localparam int FONT_AW     = CODE_BITS + ROW_BITS;
	localparam int FONT_DEPTH  = 1 << FONT_AW;
	localparam int XW          = 13;
	localparam int AW          = 34;
	localparam int PROD_W      = COORD_BITS + XW;

	localparam logic [ROW_BITS-1:0]   ROW_LAST  = ROW_BITS'(GLYPH_ROWS - 1);
	localparam logic [COORD_BITS-1:0] Y_MAX     = '1;
	localparam logic [XW-1:0]         CELL_COLS = XW'(8);
	localparam logic [7:0]            MASK_FULL = 8'hff;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Command codes
	typedef enum logic [2:0] {
		OP_LOAD_FONT      = 3'd0,
		OP_PUT_CURSOR     = 3'd1,
		OP_PUT_AT         = 3'd2,
		OP_BACKSPACE      = 3'd3,
		OP_NEWLINE        = 3'd4,
		OP_CENTER         = 3'd5,
		OP_CENTER_NEWLINE = 3'd6
	} op_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_LINE_STRIDE   = 3'd2,
		REG_FRAME_BASE    = 3'd3,
		REG_TEXT_COLOUR   = 3'd4,
		REG_CLEAR_COLOUR  = 3'd5
	} reg_idx_t;

	// Work for the back end
	typedef enum logic [1:0] {
		JOB_LOAD  = 2'd0,
		JOB_GLYPH = 2'd1,
		JOB_ERASE = 2'd2
	} job_kind_t;

	typedef struct packed {
		logic [2:0]            opcode;
		logic [7:0]            char_code;
		logic [3:0]            glyph_row;
		logic [7:0]            font_byte;
		logic [COORD_BITS-1:0] x_pos;
		logic [COORD_BITS-1:0] y_pos;
	} cmd_t;

	typedef struct packed {
		logic [AW-1:0] pixel_address;
		logic [7:0]    pixel_mask;
		logic [31:0]   pixel_colour;
		logic          last_row;
	} pix_t;

	typedef struct packed {
		job_kind_t             kind;
		logic [CODE_BITS-1:0]  code;
		logic [ROW_BITS-1:0]   row;
		logic [7:0]            fbyte;
		logic [XW-1:0]         x;
		logic [COORD_BITS-1:0] y;
	} job_t;

	typedef struct packed {
		logic [XW-1:0] screen_width;
		logic [XW-1:0] screen_height;
		logic [XW-1:0] line_stride;
		logic [31:0]   frame_base;
		logic [31:0]   text_colour;
		logic [31:0]   clear_colour;
	} cfg_t;

endpackage

// ===== rtl/bitmap_font_text_console_top.sv =====
// Top level of the bitmap font text console: configuration registers and
// the front end, job queue and back end. Depends on btc_pkg and all rtl/ modules.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one command word per accepted
//   edge. Font loads, cursor moves and drawing commands all enter here.
//   pix channel (pix_valid / pix_stall / pix): row write words. Each drawing
//   command (put character, backspace) yields 16 words, top row first, the
//   last one with last_row set.
//   cfg port (cfg_we / cfg_index / cfg_data): register write per edge with
//   cfg_we high; write only while the block is idle.
// Path: an accepted command passes the job queue, the setup stage, the row
// sequencer and the output register before its first row word is valid.
// Throughput: the single font store read port serves one row per cycle, so the
// rows follow one per cycle while pix is not stalled. Font loads write the store
// and yield no row words; cursor moves complete at acceptance.
// cmd_stall rises when the four-entry job queue is full. A stall on pix holds
// the current word and the back end, while the front keeps accepting until
// the queue fills.
// Reset clears the cursor to (0,0) and the registers to their defaults; the
// font store has no reset and must be loaded before use.
module bitmap_font_text_console_top
	import btc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        pix_valid,
	input  logic        pix_stall,
	output pix_t        pix,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic q_push, q_pop, q_full, q_empty;
	job_t push_job, head_job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= XW'(640);
			cfg_q.screen_height <= XW'(480);
			cfg_q.line_stride   <= XW'(640);
			cfg_q.frame_base    <= '0;
			cfg_q.text_colour   <= 32'hffff_ffff;
			cfg_q.clear_colour  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[XW-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[XW-1:0];
				REG_LINE_STRIDE:   cfg_q.line_stride   <= cfg_data[XW-1:0];
				REG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data;
				REG_TEXT_COLOUR:   cfg_q.text_colour   <= cfg_data;
				REG_CLEAR_COLOUR:  cfg_q.clear_colour  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	btc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	btc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.job_in  (push_job),
		.pop     (q_pop),
		.job_out (head_job),
		.full    (q_full),
		.empty   (q_empty)
	);

	btc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_job     (head_job),
		.q_pop     (q_pop),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

endmodule

// ===== rtl/btc_front.sv =====
// Front end: accepts command words, keeps the text cursor and turns
// drawing and font load commands into jobs. Depends on btc_pkg.
module btc_front
	import btc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	input  cfg_t cfg,
	input  logic q_full,
	output logic q_push,
	output job_t q_job
);

	logic [XW-1:0]         cursor_x_q, cursor_x_d;
	logic [COORD_BITS-1:0] cursor_y_q, cursor_y_d;
	logic                  accept;

	// cursor arithmetic
	logic [XW+1:0]         adv_x;
	logic                  wrap;
	logic [COORD_BITS:0]   y_up;
	logic [COORD_BITS-1:0] y_sat, y_back, bs_y1, bs_y1_back;
	logic [XW-1:0]         bs_x1, bs_left, half_w;

	assign cmd_stall = q_full;
	assign accept    = cmd_valid && !q_full;

	always_comb begin
		adv_x      = {2'b00, cursor_x_q} + (XW+2)'(CELL_COLS);
		wrap       = (adv_x + (XW+2)'(CELL_COLS)) > {2'b00, cfg.screen_width};
		y_up       = {1'b0, cursor_y_q} + (COORD_BITS+1)'(GLYPH_ROWS);
		y_sat      = (y_up > {1'b0, Y_MAX}) ? Y_MAX : y_up[COORD_BITS-1:0];
		y_back     = (cursor_y_q >= COORD_BITS'(GLYPH_ROWS)) ?
			cursor_y_q - COORD_BITS'(GLYPH_ROWS) : '0;
		// backspace from column 0 first steps back one line
		bs_x1      = (cursor_x_q == '0) ? cfg.screen_width : cursor_x_q;
		bs_y1      = (cursor_x_q == '0) ? y_back : cursor_y_q;
		bs_y1_back = (bs_y1 >= COORD_BITS'(GLYPH_ROWS)) ?
			bs_y1 - COORD_BITS'(GLYPH_ROWS) : '0;
		bs_left    = (bs_x1 >= CELL_COLS) ? bs_x1 - CELL_COLS : '0;
		half_w     = {1'b0, cfg.screen_width[XW-1:1]};
	end

	// command decode
	always_comb begin
		cursor_x_d  = cursor_x_q;
		cursor_y_d  = cursor_y_q;
		q_push      = 1'b0;
		q_job.kind  = JOB_GLYPH;
		q_job.code  = cmd.char_code;
		q_job.row   = cmd.glyph_row;
		q_job.fbyte = cmd.font_byte;
		q_job.x     = {1'b0, cmd.x_pos};
		q_job.y     = cmd.y_pos;
		unique case (cmd.opcode)
			OP_LOAD_FONT: begin
				q_push     = accept;
				q_job.kind = JOB_LOAD;
			end
			OP_PUT_CURSOR: begin
				q_push  = accept;
				q_job.x = cursor_x_q;
				q_job.y = cursor_y_q;
				if (wrap) begin
					cursor_x_d = '0;
					cursor_y_d = y_sat;
				end else begin
					cursor_x_d = adv_x[XW-1:0];
				end
			end
			OP_PUT_AT: begin
				q_push = accept;
			end
			OP_BACKSPACE: begin
				q_push     = accept;
				q_job.kind = JOB_ERASE;
				q_job.x    = bs_left;
				q_job.y    = bs_y1;
				if (bs_x1 < CELL_COLS) begin
					cursor_x_d = cfg.screen_width;
					cursor_y_d = bs_y1_back;
				end else begin
					cursor_x_d = bs_x1 - CELL_COLS;
					cursor_y_d = bs_y1;
				end
			end
			OP_NEWLINE: begin
				cursor_x_d = '0;
				cursor_y_d = y_sat;
			end
			OP_CENTER: begin
				cursor_x_d = half_w;
				cursor_y_d = cfg.screen_height[XW-1:1];
			end
			OP_CENTER_NEWLINE: begin
				cursor_x_d = half_w;
				cursor_y_d = y_sat;
			end
			default: begin
			end
		endcase
	end

	// cursor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (accept) begin
			cursor_x_q <= cursor_x_d;
			cursor_y_q <= cursor_y_d;
		end
	end

endmodule

// ===== rtl/btc_queue.sv =====
// Short job queue between front and back end, built from flops.
// Depends on btc_pkg.
module btc_queue
	import btc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	input  logic pop,
	output job_t job_out,
	output logic full,
	output logic empty
);

	job_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full    = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign job_out = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");

endmodule

// ===== rtl/btc_back.sv =====
// Back end: setup stage, font store, row sequencer and output register. Draws
// one row word per cycle for each character cell while pix is not stalled. Depends on btc_pkg.
module btc_back
	import btc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_empty,
	input  job_t q_job,
	output logic q_pop,
	output logic pix_valid,
	input  logic pix_stall,
	output pix_t pix
);

	logic [7:0] font_mem [FONT_DEPTH];

	// setup stage: row-0 offset product
	logic              s1_valid_q;
	job_t              job_s1;
	logic [PROD_W-1:0] prod_s1;

	// row sequencer
	logic                 busy_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [AW-1:0]        addr_s2;
	logic [CODE_BITS-1:0] code_s2;
	logic                 erase_s2;

	// output register
	logic          pix_valid_q;
	logic [AW-1:0] addr_s3;
	logic          erase_s3, last_s3;
	logic [7:0]    rd_q;

	logic out_free, issue, last_issue, seq_load, s1_take;

	assign out_free   = !pix_valid_q || !pix_stall;
	assign issue      = busy_q && out_free;
	assign last_issue = issue && (row_q == ROW_LAST);
	assign seq_load   = s1_valid_q && (!busy_q || last_issue);
	assign s1_take    = !s1_valid_q || seq_load;
	assign q_pop      = !q_empty && s1_take;

	// setup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_take) begin
			s1_valid_q <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_s1  <= q_job;
			prod_s1 <= {{XW{1'b0}}, q_job.y} * {{COORD_BITS{1'b0}}, cfg.line_stride};
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (seq_load) begin
			busy_q <= (job_s1.kind != JOB_LOAD);
			row_q  <= '0;
		end else if (issue) begin
			busy_q <= !last_issue;
			row_q  <= row_q + 1'b1;
		end
	end

	// row address walks down by one stride per row
	always_ff @(posedge clk) begin
		if (seq_load) begin
			addr_s2  <= AW'(cfg.frame_base) + AW'(job_s1.x) + AW'(prod_s1);
			code_s2  <= job_s1.code;
			erase_s2 <= (job_s1.kind == JOB_ERASE);
		end else if (issue) begin
			addr_s2 <= addr_s2 + AW'(cfg.line_stride);
		end
	end

	// font store: loads write in job order, rows read into rd_q
	always_ff @(posedge clk) begin
		if (seq_load && job_s1.kind == JOB_LOAD) begin
			font_mem[{job_s1.code, job_s1.row}] <= job_s1.fbyte;
		end
		if (issue) begin
			rd_q <= font_mem[{code_s2, row_q}];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_free) begin
			pix_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s3  <= addr_s2;
			erase_s3 <= erase_s2;
			last_s3  <= (row_q == ROW_LAST);
		end
	end

	assign pix_valid         = pix_valid_q;
	assign pix.pixel_address = addr_s3;
	assign pix.pixel_mask    = erase_s3 ? MASK_FULL : rd_q;
	assign pix.pixel_colour  = erase_s3 ? cfg.clear_colour : cfg.text_colour;
	assign pix.last_row      = last_s3;

	a_cell_start: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_load && job_s1.kind != JOB_LOAD) |=> (busy_q && row_q == '0))
		else $error("cell did not start at row zero");
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		last_issue |=> (pix_valid && pix.last_row))
		else $error("final row word not flagged");

endmodule

// ===== bench/btc_row_checker.sv =====
`timescale 1ns / 1ps
// Row write checker for the bitmap font text console: follows commands and
// register writes, predicts each row write word and compares the pix channel.
// Depends on btc_pkg.
module btc_row_checker
	import btc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  cmd_t        cmd,
	input  logic        pix_valid,
	input  logic        pix_stall,
	input  pix_t        pix,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          rows_due,
	output int          mismatches
);

	localparam int          REPORT_MAX = 10;
	localparam int unsigned LINE_STEP  = GLYPH_ROWS;

	// Shadow of the font store, cursor and registers
	logic [7:0]  font_mem [FONT_DEPTH];
	int unsigned cur_x;
	int unsigned cur_y;
	int unsigned scr_w;
	int unsigned scr_h;
	int unsigned stride;
	logic [31:0] base;
	logic [31:0] txt_col;
	logic [31:0] clr_col;

	// Row write words still to come, oldest first
	pix_t row_writes_due [$];

	function automatic int unsigned y_down(input int unsigned v);
		return (v >= LINE_STEP) ? v - LINE_STEP : 0;
	endfunction

	// Y moves down a line and saturates at the top of its range
	function automatic int unsigned y_up(input int unsigned v);
		return (v + LINE_STEP > Y_MAX) ? int'(Y_MAX) : v + LINE_STEP;
	endfunction

	// Sixteen row words of one cell, top row first
	task automatic queue_cell(input int unsigned x, input int unsigned y, input bit glyph,
			input int unsigned start, input logic [31:0] colour);
		longint unsigned addr;
		pix_t w;
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			addr = {32'd0, base} + 64'(x) + 64'(y + r) * 64'(stride);
			w.pixel_address = addr[AW-1:0];
			w.pixel_mask = glyph ? font_mem[(start + r) % FONT_DEPTH] : MASK_FULL;
			w.pixel_colour = colour;
			w.last_row = (r == GLYPH_ROWS - 1);
			row_writes_due.push_back(w);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			REG_SCREEN_WIDTH:  scr_w = val[XW-1:0];
			REG_SCREEN_HEIGHT: scr_h = val[XW-1:0];
			REG_LINE_STRIDE:   stride = val[XW-1:0];
			REG_FRAME_BASE:    base = val;
			REG_TEXT_COLOUR:   txt_col = val;
			REG_CLEAR_COLOUR:  clr_col = val;
			default: ;
		endcase
	endtask

	// One accepted command word: update the shadow state, queue its rows
	task automatic follow_command(input cmd_t c);
		int unsigned start;
		int unsigned left;
		start = (int'(c.char_code) % GLYPH_COUNT) * GLYPH_ROWS;
		case (c.opcode)
			OP_LOAD_FONT: begin
				font_mem[(start + c.glyph_row % GLYPH_ROWS) % FONT_DEPTH] = c.font_byte;
			end
			OP_PUT_CURSOR: begin
				queue_cell(cur_x, cur_y, 1'b1, start, txt_col);
				cur_x += CELL_COLS;
				// wrap when the next cell would not fit
				if (cur_x + CELL_COLS > scr_w) begin
					cur_x = 0;
					cur_y = y_up(cur_y);
				end
			end
			OP_PUT_AT: begin
				queue_cell(c.x_pos, c.y_pos, 1'b1, start, txt_col);
			end
			OP_BACKSPACE: begin
				if (cur_x == 0) begin
					cur_x = scr_w;
					cur_y = y_down(cur_y);
				end
				left = (cur_x >= CELL_COLS) ? cur_x - CELL_COLS : 0;
				queue_cell(left, cur_y, 1'b0, 0, clr_col);
				if (cur_x < CELL_COLS) begin
					cur_x = scr_w;
					cur_y = y_down(cur_y);
				end else begin
					cur_x -= CELL_COLS;
				end
			end
			OP_NEWLINE: begin
				cur_x = 0;
				cur_y = y_up(cur_y);
			end
			OP_CENTER: begin
				cur_x = scr_w / 2;
				cur_y = (scr_h / 2 > Y_MAX) ? int'(Y_MAX) : scr_h / 2;
			end
			OP_CENTER_NEWLINE: begin
				cur_x = scr_w / 2;
				cur_y = y_up(cur_y);
			end
			default: ;
		endcase
		cur_x &= (1 << XW) - 1;
	endtask

	// Compare one accepted row word with the oldest prediction
	task automatic check_row(input pix_t got);
		pix_t want;
		if (row_writes_due.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("unexpected row word: addr %h mask %h colour %h last %b",
					got.pixel_address, got.pixel_mask, got.pixel_colour, got.last_row);
		end else begin
			want = row_writes_due.pop_front();
			if (got.pixel_address !== want.pixel_address || got.pixel_mask !== want.pixel_mask ||
					got.pixel_colour !== want.pixel_colour || got.last_row !== want.last_row) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("row word mismatch at %0t", $realtime);
					$display("  expected addr %h mask %h colour %h last %b",
						want.pixel_address, want.pixel_mask, want.pixel_colour, want.last_row);
					$display("  actual   addr %h mask %h colour %h last %b",
						got.pixel_address, got.pixel_mask, got.pixel_colour, got.last_row);
				end
			end
		end
	endtask

	// Sample both channels and the register port at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x = 0;
			cur_y = 0;
			scr_w = 640;
			scr_h = 480;
			stride = 640;
			base = '0;
			txt_col = '1;
			clr_col = '0;
			row_writes_due.delete();
			rows_due = 0;
			mismatches = 0;
		end else begin
			if (pix_valid && !pix_stall)
				check_row(pix);
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (cmd_valid && !cmd_stall)
				follow_command(cmd);
			rows_due = row_writes_due.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the bitmap font text console: clock, reset, command and
// register stimulus, receiver stalls and the verdict.
// Depends on btc_pkg, bitmap_font_text_console_top and btc_row_checker.
module tb_top;
	import btc_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int PHASE_ITEMS   = 67;
	localparam int NEWLINE_RUN   = 130;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int LIMIT_NS      = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd = '0;
	logic        pix_valid;
	logic        pix_stall = 1'b1;
	pix_t        pix;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          rows_due;
	int          mismatches;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Which glyph rows have been loaded; only complete glyphs get drawn
	logic [GLYPH_ROWS-1:0] rows_loaded [GLYPH_COUNT];
	logic [7:0]            ready_codes [$];

	always #2 clk = ~clk;

	bitmap_font_text_console_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	btc_row_checker rows_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rows_due   (rows_due),
		.mismatches (mismatches)
	);

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left != 0) begin
			pix_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	// Offer one command word, with random gaps, and hold it until accepted
	task automatic offer_word(input cmd_t c);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	function automatic cmd_t noise_fields();
		cmd_t c;
		c.opcode = 3'($urandom);
		c.char_code = 8'($urandom);
		c.glyph_row = 4'($urandom);
		c.font_byte = 8'($urandom);
		c.x_pos = 12'($urandom);
		c.y_pos = 12'($urandom);
		return c;
	endfunction

	function automatic logic [7:0] pick_glyph();
		return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
	endfunction

	task automatic load_row(input logic [7:0] code, input logic [3:0] row,
			input logic [7:0] pattern);
		cmd_t c;
		c = noise_fields();
		c.opcode = OP_LOAD_FONT;
		c.char_code = code;
		c.glyph_row = row;
		c.font_byte = pattern;
		if (rows_loaded[code] != '1) begin
			rows_loaded[code][row] = 1'b1;
			if (rows_loaded[code] == '1)
				ready_codes.push_back(code);
		end
		offer_word(c);
	endtask

	task automatic load_glyph(input logic [7:0] code);
		for (int r = 0; r < GLYPH_ROWS; r++)
			load_row(code, 4'(r), 8'($urandom));
	endtask

	// Commands that carry only an opcode: every other field is noise
	task automatic send_op(input logic [2:0] op);
		cmd_t c;
		c = noise_fields();
		c.opcode = op;
		offer_word(c);
	endtask

	task automatic send_draw(input logic [2:0] op, input logic [7:0] code,
			input logic [11:0] x, input logic [11:0] y);
		cmd_t c;
		c = noise_fields();
		c.opcode = op;
		c.char_code = code;
		c.x_pos = x;
		c.y_pos = y;
		offer_word(c);
	endtask

	// One random step; reports how many words count toward the phase
	task automatic random_command(output int counted);
		int pick;
		logic [11:0] ex;
		logic [11:0] ey;
		pick = $urandom_range(0, 99);
		ex = {12{1'($urandom)}};
		ey = {12{1'($urandom)}};
		counted = 1;
		if (pick < 8 || ready_codes.size() == 0) begin
			load_glyph(8'($urandom));
			counted = GLYPH_ROWS;
		end else if (pick < 13) begin
			load_row(8'($urandom), 4'($urandom), 8'($urandom));
		end else if (pick < 43) begin
			send_draw(OP_PUT_CURSOR, pick_glyph(), 12'($urandom), 12'($urandom));
		end else if (pick < 58) begin
			send_draw(OP_PUT_AT, pick_glyph(), 12'($urandom), 12'($urandom));
		end else if (pick < 62) begin
			send_draw(OP_PUT_AT, pick_glyph(), ex, ey);
		end else if (pick < 74) begin
			send_op(OP_BACKSPACE);
		end else if (pick < 82) begin
			send_op(OP_NEWLINE);
		end else if (pick < 87) begin
			send_op(OP_CENTER);
		end else if (pick < 93) begin
			send_op(OP_CENTER_NEWLINE);
		end else begin
			send_op(OP_UNUSED);
			counted = 0;
		end
	endtask

	task automatic run_random(input int items);
		int n;
		int k;
		n = 0;
		while (n < items) begin
			random_command(k);
			n += k;
		end
	endtask

	// All six registers, one write per cycle
	task automatic program_regs(input logic [31:0] sw, input logic [31:0] sh,
			input logic [31:0] ls, input logic [31:0] fb, input logic [31:0] tc,
			input logic [31:0] cc);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= sw;
		@(negedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= sh;
		@(negedge clk);
		cfg_index <= REG_LINE_STRIDE;
		cfg_data <= ls;
		@(negedge clk);
		cfg_index <= REG_FRAME_BASE;
		cfg_data <= fb;
		@(negedge clk);
		cfg_index <= REG_TEXT_COLOUR;
		cfg_data <= tc;
		@(negedge clk);
		cfg_index <= REG_CLEAR_COLOUR;
		cfg_data <= cc;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stop offering, let every predicted row arrive, then let queued loads drain
	task automatic settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (rows_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		foreach (rows_loaded[i])
			rows_loaded[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: narrowest screen, smallest stride, top frame base
		snd_idle_pct = 24;
		rcv_idle_pct = 45;
		program_regs(8, 16, 8, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
		load_row(8'hff, 4'd0, 8'h00);
		load_row(8'hff, 4'd1, 8'hff);
		load_row(8'hff, 4'd2, 8'h80);
		load_row(8'hff, 4'd3, 8'h01);
		for (int r = 4; r < GLYPH_ROWS; r++)
			load_row(8'hff, 4'(r), 8'($urandom));
		send_draw(OP_PUT_CURSOR, 8'hff, 12'h000, 12'h000);  // wraps at once
		send_draw(OP_PUT_AT, 8'hff, 12'hfff, 12'hfff);
		send_draw(OP_PUT_AT, 8'hff, 12'h000, 12'h000);
		send_op(OP_BACKSPACE);      // x at 0: back one line
		send_op(OP_BACKSPACE);      // top line: Y clamps at 0
		send_op(OP_NEWLINE);
		send_op(OP_CENTER);         // x lands inside the first cell
		send_op(OP_BACKSPACE);      // left column clamps at 0
		send_op(OP_CENTER_NEWLINE);
		send_op(OP_UNUSED);
		settle();

		// Random geometry and colours
		program_regs($urandom_range(8, 4096), $urandom_range(16, 4096),
			$urandom_range(8, 4096), $urandom, $urandom, $urandom);
		run_random(PHASE_ITEMS);
		settle();

		// Largest geometry; drive Y into saturation, then random
		snd_idle_pct = 45;
		rcv_idle_pct = 24;
		program_regs(4096, 4096, 4096, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
		send_op(OP_CENTER);
		repeat (NEWLINE_RUN)
			send_op($urandom_range(0, 1) ? OP_NEWLINE : OP_CENTER_NEWLINE);
		run_random(PHASE_ITEMS);
		settle();

		// No idling; one long receiver hold-off fills the job queue
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		program_regs($urandom_range(8, 64), $urandom_range(16, 4096),
			$urandom_range(8, 4096), $urandom, $urandom, $urandom);
		hold_reqs <= hold_reqs + 1;
		run_random(PHASE_ITEMS);
		settle();

		if (mismatches == 0 && rows_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
